[hw/rtl/treyfer_pkg.sv]
// ----------------------------------------------------------------------------
// treyfer package
// shared constants and the fixed s-box table
// ----------------------------------------------------------------------------
package treyfer_pkg;

  localparam int unsigned RoundsDefault  = 32;
  localparam int unsigned CaptureDefault = 16;
  localparam int unsigned NumBytes       = 8;
  localparam logic [63:0] KeyReset       = 64'h004B_4341_4853_4E49;

  localparam logic [7:0] SBOX [256] = '{
    8'd65, 8'd108, 8'd108, 8'd32, 8'd111, 8'd112, 8'd101, 8'd114,
    8'd97, 8'd116, 8'd105, 8'd111, 8'd110, 8'd115, 8'd32, 8'd97,
    8'd114, 8'd101, 8'd32, 8'd98, 8'd121, 8'd116, 8'd101, 8'd45,
    8'd111, 8'd114, 8'd105, 8'd101, 8'd110, 8'd116, 8'd101, 8'd100,
    8'd44, 8'd32, 8'd97, 8'd110, 8'd100, 8'd32, 8'd116, 8'd104,
    8'd101, 8'd114, 8'd101, 8'd32, 8'd105, 8'd115, 8'd32, 8'd97,
    8'd32, 8'd115, 8'd105, 8'd110, 8'd103, 8'd108, 8'd101, 8'd32,
    8'd56, 8'd195, 8'd151, 8'd56, 8'd98, 8'd105, 8'd116, 8'd32,
    8'd83, 8'd45, 8'd98, 8'd111, 8'd120, 8'd46, 8'd32, 8'd73,
    8'd110, 8'd32, 8'd101, 8'd97, 8'd99, 8'd104, 8'd32, 8'd114,
    8'd111, 8'd117, 8'd110, 8'd100, 8'd44, 8'd32, 8'd101, 8'd97,
    8'd99, 8'd104, 8'd32, 8'd98, 8'd121, 8'd116, 8'd101, 8'd32,
    8'd104, 8'd97, 8'd115, 8'd32, 8'd97, 8'd100, 8'd100, 8'd101,
    8'd100, 8'd32, 8'd116, 8'd111, 8'd32, 8'd105, 8'd116, 8'd32,
    8'd116, 8'd104, 8'd101, 8'd32, 8'd83, 8'd45, 8'd98, 8'd111,
    8'd120, 8'd32, 8'd118, 8'd97, 8'd108, 8'd117, 8'd101, 8'd32,
    8'd111, 8'd102, 8'd32, 8'd116, 8'd104, 8'd101, 8'd32, 8'd115,
    8'd117, 8'd109, 8'd32, 8'd111, 8'd102, 8'd32, 8'd97, 8'd32,
    8'd107, 8'd101, 8'd121, 8'd32, 8'd98, 8'd121, 8'd116, 8'd101,
    8'd32, 8'd97, 8'd110, 8'd100, 8'd32, 8'd116, 8'd104, 8'd101,
    8'd32, 8'd112, 8'd114, 8'd101, 8'd118, 8'd105, 8'd111, 8'd117,
    8'd115, 8'd32, 8'd100, 8'd97, 8'd116, 8'd97, 8'd32, 8'd98,
    8'd121, 8'd116, 8'd101, 8'd44, 8'd32, 8'd116, 8'd104, 8'd101,
    8'd110, 8'd32, 8'd105, 8'd116, 8'd32, 8'd105, 8'd115, 8'd32,
    8'd114, 8'd111, 8'd116, 8'd97, 8'd116, 8'd101, 8'd100, 8'd32,
    8'd108, 8'd101, 8'd102, 8'd116, 8'd32, 8'd111, 8'd110, 8'd101,
    8'd32, 8'd98, 8'd105, 8'd116, 8'd46, 8'd32, 8'd84, 8'd104,
    8'd101, 8'd32, 8'd97, 8'd108, 8'd103, 8'd111, 8'd114, 8'd105,
    8'd116, 8'd104, 8'd109, 8'd32, 8'd105, 8'd115, 8'd32, 8'd101,
    8'd120, 8'd116, 8'd114, 8'd101, 8'd109, 8'd101, 8'd108, 8'd121,
    8'd32, 8'd115, 8'd105, 8'd109, 8'd112, 8'd108, 8'd101, 8'd46,
    8'd32, 8'd73, 8'd78, 8'd83, 8'd72, 8'd65, 8'd67, 8'd75
  };

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

[hw/rtl/treyfer_block_encrypt.sv]
// ----------------------------------------------------------------------------
// treyfer block encrypt
// 64-bit treyfer encryption over a ring of eight byte cells
// ----------------------------------------------------------------------------
// A block runs 8*ROUNDS steps from start to done_o, each updating one byte,
// with the s-box lookup of each step feeding the next; done_o is registered
// after the last step. busy is high from the accepting edge through the result
// strobe cycle; the result is valid for the single cycle done_o is high and
// cannot be held off. The ring rotates by one byte each step, so the byte to
// update and the key byte to add sit in fixed cells; the real block order is
// restored by a one-byte rotate.
module treyfer_block_encrypt import treyfer_pkg::*; #(
  parameter int unsigned ROUNDS        = RoundsDefault,
  parameter int unsigned CAPTURE_ROUND = CaptureDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plain_block_i,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  output logic        done_o,
  output logic [63:0] cipher_block_o,
  output logic [63:0] mid_block_o
);

  localparam int unsigned Steps = NumBytes * ROUNDS;
  localparam int unsigned StepW = $clog2(Steps + 1);
  localparam int unsigned CapSt = NumBytes * CAPTURE_ROUND;

  logic [63:0] key_q;
  state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [7:0]  t_q, t_d;
  logic [63:0] mid_q, mid_d;
  logic        done_q, done_d;
  cell_ctrl_t  ctrl;
  logic [7:0]  blk [NumBytes];
  logic [7:0]  key [NumBytes];
  logic [7:0]  nblk [NumBytes];
  logic [7:0]  nkey [NumBytes];
  logic [7:0]  newb, sum;
  logic [63:0] ring;

  assign ctrl.load  = start && !busy;
  assign ctrl.shift = (state_q == StRun);

  // ring cell 0 holds block[(i+1)%8] at step i, cell 7 holds key[i%8]
  for (genvar c = 0; c < NumBytes; c++) begin : g_cell
    treyfer_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_blk_i (plain_block_i[8*((c+1)%NumBytes) +: 8]),
      .load_key_i (key_q[8*((c+1)%NumBytes) +: 8]),
      .next_blk_i (nblk[c]),
      .next_key_i (nkey[c]),
      .blk_o      (blk[c]),
      .key_o      (key[c])
    );
    assign ring[8*c +: 8] = blk[c];
    if (c == NumBytes - 1) begin : g_last
      assign nblk[c] = newb;
    end else begin : g_mid
      assign nblk[c] = blk[c+1];
    end
    if (c == NumBytes - 1) begin : g_klast
      assign nkey[c] = key[0];
    end else begin : g_kmid
      assign nkey[c] = key[c+1];
    end
  end

  assign sum  = t_q + key[NumBytes-1];
  always_comb begin
    logic [7:0] s;
    s    = SBOX[sum] + blk[0];
    newb = {s[6:0], s[7]};
  end

  // ring at step i is the block rotated right by (i+1)%8 bytes; step counts
  // are multiples of 8 at capture and end, so undo one byte
  logic [63:0] blk_order;
  assign blk_order = {ring[55:0], ring[63:56]};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    t_d     = t_q;
    mid_d   = mid_q;
    done_d  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (ctrl.load) begin
          state_d = StRun;
          step_d  = '0;
          t_d     = plain_block_i[7:0];
          mid_d   = (CapSt == 0) ? plain_block_i : '0;
        end
      end
      StRun: begin
        t_d    = newb;
        step_d = step_q + 1'b1;
        // block after this step: byte 0 is the new byte, the rest still in the ring
        if (CapSt != 0 && CapSt < Steps && step_q == StepW'(CapSt - 1)) begin
          mid_d = {ring[63:8], newb};
        end
        if (step_q == StepW'(Steps - 1)) begin
          state_d = StIdle;
          done_d  = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      done_q  <= 1'b0;
      key_q   <= KeyReset;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
      if (cfg_we_i) key_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    mid_q <= mid_d;
  end

  assign busy           = (state_q != StIdle) || done_q;
  assign done_o         = done_q;
  assign cipher_block_o = blk_order;
  assign mid_block_o    = mid_q;

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == StRun)) else $error("done without a run");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> busy) else $error("run while not busy");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (step_q < StepW'(Steps))) else $error("step overrun");
`endif

endmodule

[hw/rtl/treyfer_cell.sv]
// ----------------------------------------------------------------------------
// treyfer cell
// one byte of the rotating block ring, with its key byte alongside
// ----------------------------------------------------------------------------
module treyfer_cell import treyfer_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] load_blk_i,
  input  logic [7:0] load_key_i,
  input  logic [7:0] next_blk_i,
  input  logic [7:0] next_key_i,
  output logic [7:0] blk_o,
  output logic [7:0] key_o
);

  logic [7:0] blk_q, blk_d, key_q, key_d;

  always_comb begin
    blk_d = blk_q;
    key_d = key_q;
    if (ctrl_i.load) begin
      blk_d = load_blk_i;
      key_d = load_key_i;
    end else if (ctrl_i.shift) begin
      blk_d = next_blk_i;
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    key_q <= key_d;
  end

  assign blk_o = blk_q;
  assign key_o = key_q;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// treyfer block encrypt testbench
// drives plaintext blocks under several key settings and checks every
// ciphertext and mid-point block against an in-bench model of the cipher
// ----------------------------------------------------------------------------
module testbench;
  import treyfer_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Rounds    = RoundsDefault;
  localparam int unsigned CapRound  = CaptureDefault;
  localparam int unsigned DrainWait = 8 * Rounds + 40;
  localparam int unsigned StallMax  = 4000;
  localparam int unsigned NumRandom = 1830;

  typedef struct packed {
    logic [63:0] cipher;
    logic [63:0] mid;
  } block_pair_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] plain;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] plain_block_i;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;
  logic        done_o;
  logic [63:0] cipher_block_o;
  logic [63:0] mid_block_o;

  block_pair_t pending_blocks[$];
  logic [63:0] key_shadow;
  int unsigned idle_pct;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_keys;
  int unsigned stall_cnt;

  treyfer_block_encrypt #(
    .ROUNDS       (Rounds),
    .CAPTURE_ROUND(CapRound)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .plain_block_i (plain_block_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .cipher_block_o(cipher_block_o),
    .mid_block_o   (mid_block_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic block_pair_t encrypt_block(logic [63:0] key, logic [63:0] plain);
    logic [7:0] blk [8];
    logic [7:0] run;
    int unsigned pos;
    block_pair_t res;
    res.mid = '0;
    for (int j = 0; j < 8; j++) blk[j] = plain[8*j +: 8];
    run = blk[0];
    for (int unsigned i = 0; i < 8 * Rounds; i++) begin
      if (i == 8 * CapRound) begin
        for (int j = 0; j < 8; j++) res.mid[8*j +: 8] = blk[j];
      end
      pos = (i + 1) % 8;
      run = run + key[8*(i%8) +: 8];
      run = SBOX[run] + blk[pos];
      run = {run[6:0], run[7]};
      blk[pos] = run;
    end
    for (int j = 0; j < 8; j++) res.cipher[8*j +: 8] = blk[j];
    return res;
  endfunction

  // result checker: done lasts one cycle and cannot be stalled
  always @(posedge clk_i) begin
    block_pair_t exp_pair;
    if (rst_ni && done_o) begin
      if (pending_blocks.size() == 0) begin
        $error("unexpected transaction: cipher_block %h", cipher_block_o);
        n_errors++;
      end else begin
        exp_pair = pending_blocks.pop_front();
        n_checked++;
        if (cipher_block_o !== exp_pair.cipher) begin
          $error("cipher_block expected %h actual %h", exp_pair.cipher, cipher_block_o);
          n_errors++;
        end
        if (mid_block_o !== exp_pair.mid) begin
          $error("mid_block expected %h actual %h", exp_pair.mid, mid_block_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > StallMax) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // leaves start high after the accepting edge; caller or next call lowers it
  task automatic send_block(logic [63:0] plain);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start         <= 1'b1;
    plain_block_i <= plain;
    do @(posedge clk_i); while (busy);
    pending_blocks.push_back(encrypt_block(key_shadow, plain));
    n_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_key(logic [63:0] key);
    drain();
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= key;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_shadow = key;
    n_keys++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  stim_row_t directed_rows[] = '{
    '{KeyReset, 64'h0},
    '{KeyReset, 64'hFFFF_FFFF_FFFF_FFFF},
    '{KeyReset, 64'h0000_0000_0000_0001},
    '{KeyReset, 64'h8000_0000_0000_0000},
    '{KeyReset, 64'h0123_4567_89AB_CDEF},
    '{64'h0,    64'h0},
    '{64'h0,    64'hFFFF_FFFF_FFFF_FFFF},
    '{64'h0,    64'hAAAA_AAAA_AAAA_AAAA},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555},
    '{64'h8000_0000_0000_0001, 64'h00FF_00FF_00FF_00FF},
    '{64'h8000_0000_0000_0001, 64'hFF00_FF00_FF00_FF00}
  };

  initial begin
    logic [63:0] key_choice;
    start         = 1'b0;
    plain_block_i = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    key_shadow    = KeyReset;
    idle_pct      = 30;
    n_errors = 0; n_sent = 0; n_checked = 0; n_keys = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].key != key_shadow) load_key(directed_rows[r].key);
      send_block(directed_rows[r].plain);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) idle_pct = 52;
      if (n == 2 * NumRandom / 3) idle_pct = 0;
      if (n % 150 == 0) begin
        case ($urandom_range(3))
          0: key_choice = '0;
          1: key_choice = '1;
          default: key_choice = rand64();
        endcase
        load_key(key_choice);
      end else if ($urandom_range(99) < 3) begin
        drain();
      end
      send_block(rand64());
    end

    drain();
    repeat (DrainWait) @(posedge clk_i);
    $display("covered %0d blocks under %0d key loads, %0d results checked",
             n_sent, n_keys, n_checked);
    $display("sender idle ratios 30, 52 and 0 percent, with full drains between");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[treyfer_block_encrypt.f]
hw/rtl/treyfer_pkg.sv
hw/rtl/treyfer_cell.sv
hw/rtl/treyfer_block_encrypt.sv
dv/testbench.sv
